/* rtl/jst_pkg.sv */
// Shared types, codes and character helpers for the JSON stream tokenizer.
`timescale 1ns / 1ps
package jst_pkg;

    typedef enum logic [4:0] {
        ST_EWS   = 5'd0,
        ST_START = 5'd1,
        ST_FIN   = 5'd2,
        ST_NULL  = 5'd3,
        ST_CST   = 5'd4,
        ST_CMT   = 5'd5,
        ST_CEOL  = 5'd6,
        ST_CEND  = 5'd7,
        ST_STR   = 5'd8,
        ST_ESC   = 5'd9,
        ST_UNI   = 5'd10,
        ST_BOOL  = 5'd11,
        ST_NUM   = 5'd12,
        ST_ARR   = 5'd13,
        ST_ASEP  = 5'd14,
        ST_OFS   = 5'd15,
        ST_OFLD  = 5'd16,
        ST_OFE   = 5'd17,
        ST_OVAL  = 5'd18,
        ST_OSEP  = 5'd19
    } lvl_state_t;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_OBJ_BEGIN = 4'd1;
    localparam logic [3:0] EV_OBJ_END   = 4'd2;
    localparam logic [3:0] EV_ARR_BEGIN = 4'd3;
    localparam logic [3:0] EV_ARR_END   = 4'd4;
    localparam logic [3:0] EV_NULL      = 4'd5;
    localparam logic [3:0] EV_TRUE      = 4'd6;
    localparam logic [3:0] EV_FALSE     = 4'd7;
    localparam logic [3:0] EV_STR_BYTE  = 4'd8;
    localparam logic [3:0] EV_STR_END   = 4'd9;
    localparam logic [3:0] EV_NAME_BYTE = 4'd10;
    localparam logic [3:0] EV_NAME_END  = 4'd11;
    localparam logic [3:0] EV_NUM_BYTE  = 4'd12;
    localparam logic [3:0] EV_NUM_END   = 4'd13;
    localparam logic [3:0] EV_ERROR     = 4'd14;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_UNEXPECTED = 4'd1;
    localparam logic [3:0] ERR_NULL       = 4'd2;
    localparam logic [3:0] ERR_COMMENT    = 4'd3;
    localparam logic [3:0] ERR_ESCAPE     = 4'd4;
    localparam logic [3:0] ERR_BOOL       = 4'd5;
    localparam logic [3:0] ERR_ARRAY      = 4'd6;
    localparam logic [3:0] ERR_NAME       = 4'd7;
    localparam logic [3:0] ERR_SEPARATOR  = 4'd8;
    localparam logic [3:0] ERR_DEPTH      = 4'd9;

    localparam logic [1:0] WORD_NULL  = 2'd0;
    localparam logic [1:0] WORD_TRUE  = 2'd1;
    localparam logic [1:0] WORD_FALSE = 2'd2;

    typedef struct packed {
        lvl_state_t  st;
        lvl_state_t  rs;
        logic [2:0]  mpos;
        logic [15:0] uacc;
        logic        mtrue;
        logic        ndec;
        logic [3:0]  err;
        logic [31:0] line;
        logic [31:0] col;
    } tok_state_t;

    localparam tok_state_t STATE_INIT = '{
        st: ST_EWS, rs: ST_START, mpos: 3'd0, uacc: 16'd0, mtrue: 1'b0,
        ndec: 1'b0, err: ERR_NONE, line: 32'd1, col: 32'd1
    };

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       dec;
    } tok_event_t;

    typedef struct packed {
        tok_event_t [2:0] ev;
        logic [1:0]       count;
        logic [3:0]       err;
        logic [31:0]      line;
        logic [31:0]      col;
        logic [4:0]       nest;
        logic             fin;
    } tok_result_t;

    typedef struct packed {
        logic push;
        logic push_bit;
        logic pop;
    } stack_op_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (is_digit(c)) begin
            v = c - 8'h30;
        end else if (c >= "a" && c <= "f") begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    // Character expected at a position of one of the literal words.
    function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        unique case ({w, p})
            {WORD_NULL, 3'd0}:  ch = "n";
            {WORD_NULL, 3'd1}:  ch = "u";
            {WORD_NULL, 3'd2}:  ch = "l";
            {WORD_NULL, 3'd3}:  ch = "l";
            {WORD_TRUE, 3'd0}:  ch = "t";
            {WORD_TRUE, 3'd1}:  ch = "r";
            {WORD_TRUE, 3'd2}:  ch = "u";
            {WORD_TRUE, 3'd3}:  ch = "e";
            {WORD_FALSE, 3'd0}: ch = "f";
            {WORD_FALSE, 3'd1}: ch = "a";
            {WORD_FALSE, 3'd2}: ch = "l";
            {WORD_FALSE, 3'd3}: ch = "s";
            {WORD_FALSE, 3'd4}: ch = "e";
            default:            ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Simple escape decode: bit 8 flags a valid escape letter.
    function automatic logic [8:0] esc_char(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h22, 8'h5c, 8'h2f: r = {1'b1, c};
            "b":                 r = {1'b1, 8'h08};
            "n":                 r = {1'b1, 8'h0a};
            "r":                 r = {1'b1, 8'h0d};
            "t":                 r = {1'b1, 8'h09};
            "f":                 r = {1'b1, 8'h0c};
            default:             r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic void push_ev(inout tok_event_t [2:0] evs, inout logic [1:0] n,
                                    input logic [3:0] kind, input logic [7:0] data,
                                    input logic dec);
        if (n != 2'd3) begin
            evs[n] = '{kind: kind, data: data, dec: dec};
            n = n + 2'd1;
        end
    endfunction

endpackage

/* rtl/json_stream_tokenizer_unit.sv */
// Top level of the JSON stream tokenizer: input skid, tokenizer state and result buffer.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tuser = op, tdata = text byte
//  m_      | out       | m_tvalid/m_tready  | tuser = event, tdata = byte/status, tlast
//
//  Each accepted transfer is decoded in the cycle it leaves the input register, so
//  one text byte is taken per clock. A byte that raises two or three events holds the
//  result buffer for that many output transfers, and the next byte waits behind it.
//  Reset (aresetn low at a clock edge) returns the tokenizer to the start of a document.
//  s_tready is a registered skid flag, so downstream stalls never reach the input
//  combinationally; the nesting stack is a shift register with one bit per level.
//
module json_stream_tokenizer_unit import jst_pkg::*; #(
    parameter int MAX_NEST = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic [1:0]  s_tuser,    // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // [7:0] data_byte, [8] is_decimal, [12:9] error_code,
                                    // [44:13] line_number, [76:45] column_number,
                                    // [81:77] nest_depth, [82] doc_finished, rest zero
    output logic [3:0]  m_tuser,    // [3:0] event_res
    output logic        m_tlast     // last event caused by the item
);

    localparam int DW = $clog2(MAX_NEST);

    // input register and skid stage
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_op_reg, in_op_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic        sk_valid_reg, sk_valid_next;
    logic [1:0]  sk_op_reg, sk_op_next;
    logic [7:0]  sk_byte_reg, sk_byte_next;

    // tokenizer state
    tok_state_t          state_reg, state_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [MAX_NEST-1:0] stack_reg, stack_next;

    tok_state_t    step_state;
    logic [DW-1:0] step_depth;
    stack_op_t     step_sop;
    tok_result_t   step_res;

    logic s_xfer;
    logic buf_free;
    logic take;

    assign s_tready = !sk_valid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign take     = in_valid_reg && buf_free;

    // Hold an item in the skid stage while the input register is stuck behind a busy buffer.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_op_next    = in_op_reg;
        in_byte_next  = in_byte_reg;
        sk_valid_next = sk_valid_reg;
        sk_op_next    = sk_op_reg;
        sk_byte_next  = sk_byte_reg;
        if (!in_valid_reg || take) begin
            if (sk_valid_reg) begin
                in_valid_next = 1'b1;
                in_op_next    = sk_op_reg;
                in_byte_next  = sk_byte_reg;
                sk_valid_next = 1'b0;
            end else if (s_xfer) begin
                in_valid_next = 1'b1;
                in_op_next    = s_tuser;
                in_byte_next  = s_tdata;
            end else begin
                in_valid_next = 1'b0;
            end
        end else if (s_xfer) begin
            sk_valid_next = 1'b1;
            sk_op_next    = s_tuser;
            sk_byte_next  = s_tdata;
        end
    end

    jst_step #(
        .MAX_NEST (MAX_NEST)
    ) u_step (
        .op            (in_op_reg),
        .text_byte     (in_byte_reg),
        .state_in      (state_reg),
        .depth_in      (depth_reg),
        .parent_is_arr (stack_reg[0]),
        .state_out     (step_state),
        .depth_out     (step_depth),
        .stack_op      (step_sop),
        .result        (step_res)
    );

    // Advance the tokenizer only when the item's events have somewhere to go.
    always_comb begin
        state_next = state_reg;
        depth_next = depth_reg;
        stack_next = stack_reg;
        if (take) begin
            state_next = step_state;
            depth_next = step_depth;
            if (step_sop.push) begin
                stack_next = {stack_reg[MAX_NEST-2:0], step_sop.push_bit};
            end else if (step_sop.pop) begin
                stack_next = {1'b0, stack_reg[MAX_NEST-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            sk_valid_reg <= 1'b0;
            state_reg    <= STATE_INIT;
            depth_reg    <= '0;
            stack_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            sk_valid_reg <= sk_valid_next;
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            stack_reg    <= stack_next;
        end
        in_op_reg   <= in_op_next;
        in_byte_reg <= in_byte_next;
        sk_op_reg   <= sk_op_next;
        sk_byte_reg <= sk_byte_next;
    end

    jst_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .res_in   (step_res),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/jst_step.sv */
// Combinational next-state and event logic for one tokenizer item.
`timescale 1ns / 1ps
module jst_step import jst_pkg::*; #(
    parameter int MAX_NEST = 32
) (
    input  logic [1:0]                    op,
    input  logic [7:0]                    text_byte,
    input  tok_state_t                    state_in,
    input  logic [$clog2(MAX_NEST)-1:0]   depth_in,
    input  logic                          parent_is_arr,
    output tok_state_t                    state_out,
    output logic [$clog2(MAX_NEST)-1:0]   depth_out,
    output stack_op_t                     stack_op,
    output tok_result_t                   result
);

    localparam int DW = $clog2(MAX_NEST);
    localparam logic [DW-1:0] TOP_DEPTH = DW'(MAX_NEST - 1);
    // longest chain of state hops one byte can cause, plus margin
    localparam int HOPS = 6;

    tok_state_t       s;
    logic [DW-1:0]    d;
    stack_op_t        sop;
    tok_event_t [2:0] evs;
    logic [1:0]       n;
    logic [7:0]       c;
    logic             done;
    logic             colinc;
    logic             brk;
    logic             ret;
    logic [3:0]       fcode;
    logic [3:0]       skind;
    logic [8:0]       esc;
    logic [15:0]      a;
    logic [2:0]       wlen;
    logic [1:0]       wsel;

    always_comb begin
        s      = state_in;
        d      = depth_in;
        sop    = '0;
        evs    = '0;
        n      = 2'd0;
        c      = 8'h00;
        done   = 1'b0;
        colinc = 1'b1;
        brk    = 1'b0;
        ret    = 1'b0;
        fcode  = ERR_NONE;
        skind  = EV_STR_BYTE;
        esc    = 9'd0;
        a      = 16'd0;
        wlen   = 3'd4;
        wsel   = WORD_NULL;

        if (op == OP_BEGIN) begin
            s = STATE_INIT;
            d = '0;
        end else if (op == OP_NOP) begin
            s = state_in;
        end else if (state_in.err != ERR_NONE) begin
            push_ev(evs, n, EV_ERROR, 8'h00, 1'b0);
        end else begin
            c = (op == OP_BYTE) ? text_byte : 8'h00;
            if (c == 8'h0a) begin
                s.line = s.line + 32'd1;
                s.col  = 32'd1;
            end
            for (int i = 0; i < HOPS; i++) begin
                if (!done) begin
                    brk   = 1'b0;
                    ret   = 1'b0;
                    fcode = ERR_NONE;
                    skind = (s.rs == ST_OFLD) ? EV_NAME_BYTE : EV_STR_BYTE;
                    unique case (s.st)
                        ST_EWS: begin
                            if (is_space(c)) begin
                                brk = 1'b1;
                            end else if (c == "/") begin
                                s.st = ST_CST;
                                brk  = 1'b1;
                            end else begin
                                s.st = s.rs;
                            end
                        end
                        ST_START: begin
                            if (c == "{") begin
                                s.st = ST_EWS;
                                s.rs = ST_OFS;
                                push_ev(evs, n, EV_OBJ_BEGIN, 8'h00, 1'b0);
                                brk = 1'b1;
                            end else if (c == "[") begin
                                s.st = ST_EWS;
                                s.rs = ST_ARR;
                                push_ev(evs, n, EV_ARR_BEGIN, 8'h00, 1'b0);
                                brk = 1'b1;
                            end else if (c == "n") begin
                                s.st   = ST_NULL;
                                s.mpos = 3'd0;
                            end else if (c == 8'h22) begin
                                s.st = ST_STR;
                                brk  = 1'b1;
                            end else if (c == "t" || c == "f") begin
                                s.st    = ST_BOOL;
                                s.mpos  = 3'd0;
                                s.mtrue = (c == "t");
                            end else if (is_digit(c) || c == "-") begin
                                s.st   = ST_NUM;
                                s.ndec = 1'b0;
                            end else if (c != 8'h00) begin
                                fcode = ERR_UNEXPECTED;
                            end else begin
                                brk = 1'b1;
                            end
                        end
                        ST_FIN: begin
                            if (d == '0) begin
                                ret = 1'b1;
                            end else begin
                                // drop back to the enclosing level
                                d       = d - 1'b1;
                                sop.pop = 1'b1;
                                s.st    = parent_is_arr ? ST_ASEP : ST_EWS;
                                s.rs    = parent_is_arr ? ST_ARR : ST_OSEP;
                            end
                        end
                        ST_NULL, ST_BOOL: begin
                            wsel = (s.st == ST_NULL) ? WORD_NULL :
                                   (s.mtrue ? WORD_TRUE : WORD_FALSE);
                            wlen = (wsel == WORD_FALSE) ? 3'd5 : 3'd4;
                            if (s.mpos >= wlen || c != word_char(wsel, s.mpos)) begin
                                fcode = (s.st == ST_NULL) ? ERR_NULL : ERR_BOOL;
                            end else begin
                                s.mpos = s.mpos + 3'd1;
                                if (s.mpos == wlen) begin
                                    push_ev(evs, n, (wsel == WORD_NULL) ? EV_NULL :
                                            (wsel == WORD_TRUE) ? EV_TRUE : EV_FALSE,
                                            8'h00, 1'b0);
                                    s.rs = ST_FIN;
                                    s.st = ST_EWS;
                                end
                                brk = 1'b1;
                            end
                        end
                        ST_CST: begin
                            if (c == "*") begin
                                s.st = ST_CMT;
                                brk  = 1'b1;
                            end else if (c == "/") begin
                                s.st = ST_CEOL;
                                brk  = 1'b1;
                            end else begin
                                fcode = ERR_COMMENT;
                            end
                        end
                        ST_CMT: begin
                            if (c == "*") begin
                                s.st = ST_CEND;
                            end
                            brk = 1'b1;
                        end
                        ST_CEOL: begin
                            if (c == 8'h0a) begin
                                s.st = ST_EWS;
                            end
                            brk = 1'b1;
                        end
                        ST_CEND: begin
                            if (c == "/") begin
                                s.st = ST_EWS;
                                brk  = 1'b1;
                            end else begin
                                s.st = ST_CMT;
                            end
                        end
                        ST_STR, ST_OFLD: begin
                            if (c == 8'h22) begin
                                push_ev(evs, n, (s.st == ST_STR) ? EV_STR_END : EV_NAME_END,
                                        8'h00, 1'b0);
                                s.rs = (s.st == ST_STR) ? ST_FIN : ST_OFE;
                                s.st = ST_EWS;
                            end else if (c == 8'h5c) begin
                                s.rs = s.st;
                                s.st = ST_ESC;
                            end else begin
                                push_ev(evs, n, (s.st == ST_STR) ? EV_STR_BYTE : EV_NAME_BYTE,
                                        c, 1'b0);
                            end
                            brk = 1'b1;
                        end
                        ST_ESC: begin
                            esc = esc_char(c);
                            if (c == "u") begin
                                s.uacc = 16'd0;
                                s.mpos = 3'd0;
                                s.st   = ST_UNI;
                                brk    = 1'b1;
                            end else if (esc[8]) begin
                                push_ev(evs, n, skind, esc[7:0], 1'b0);
                                s.st = s.rs;
                                brk  = 1'b1;
                            end else begin
                                fcode = ERR_ESCAPE;
                            end
                        end
                        ST_UNI: begin
                            if (!is_hex(c)) begin
                                fcode = ERR_ESCAPE;
                            end else begin
                                a = s.uacc + ({12'd0, hex_val(c)}
                                              << {2'd3 - s.mpos[1:0], 2'b00});
                                s.uacc = a;
                                s.mpos = s.mpos + 3'd1;
                                if (s.mpos >= 3'd4) begin
                                    if (a == 16'd0) begin
                                        fcode = ERR_ESCAPE;
                                    end else begin
                                        // re-encode the code point as UTF-8
                                        if (a[15:7] == 9'd0) begin
                                            push_ev(evs, n, skind, a[7:0], 1'b0);
                                        end else if (a[15:11] == 5'd0) begin
                                            push_ev(evs, n, skind, {3'b110, a[10:6]}, 1'b0);
                                            push_ev(evs, n, skind, {2'b10, a[5:0]}, 1'b0);
                                        end else begin
                                            push_ev(evs, n, skind, {4'b1110, a[15:12]}, 1'b0);
                                            push_ev(evs, n, skind, {2'b10, a[11:6]}, 1'b0);
                                            push_ev(evs, n, skind, {2'b10, a[5:0]}, 1'b0);
                                        end
                                        s.st = s.rs;
                                        brk  = 1'b1;
                                    end
                                end else begin
                                    brk = 1'b1;
                                end
                            end
                        end
                        ST_NUM: begin
                            if (c == "." || c == "e" || c == "E") begin
                                s.ndec = 1'b1;
                                push_ev(evs, n, EV_NUM_BYTE, c, 1'b0);
                                brk = 1'b1;
                            end else if (is_digit(c) || c == "+" || c == "-") begin
                                push_ev(evs, n, EV_NUM_BYTE, c, 1'b0);
                                brk = 1'b1;
                            end else begin
                                push_ev(evs, n, EV_NUM_END, 8'h00, s.ndec);
                                s.rs = ST_FIN;
                                s.st = ST_EWS;
                            end
                        end
                        ST_ARR, ST_OVAL: begin
                            if (s.st == ST_ARR && c == "]") begin
                                push_ev(evs, n, EV_ARR_END, 8'h00, 1'b0);
                                s.rs = ST_FIN;
                                s.st = ST_EWS;
                                brk  = 1'b1;
                            end else if (d == TOP_DEPTH) begin
                                fcode = ERR_DEPTH;
                            end else begin
                                // open a child level for the element or member value
                                sop.push     = 1'b1;
                                sop.push_bit = (s.st == ST_ARR);
                                d            = d + 1'b1;
                                s.st         = ST_EWS;
                                s.rs         = ST_START;
                            end
                        end
                        ST_ASEP: begin
                            if (c == "]") begin
                                push_ev(evs, n, EV_ARR_END, 8'h00, 1'b0);
                                s.rs = ST_FIN;
                                s.st = ST_EWS;
                                brk  = 1'b1;
                            end else if (c == ",") begin
                                s.rs = ST_ARR;
                                s.st = ST_EWS;
                                brk  = 1'b1;
                            end else begin
                                fcode = ERR_ARRAY;
                            end
                        end
                        ST_OFS: begin
                            if (c == "}") begin
                                push_ev(evs, n, EV_OBJ_END, 8'h00, 1'b0);
                                s.rs = ST_FIN;
                                s.st = ST_EWS;
                                brk  = 1'b1;
                            end else if (c == 8'h22) begin
                                s.st = ST_OFLD;
                                brk  = 1'b1;
                            end else begin
                                fcode = ERR_NAME;
                            end
                        end
                        ST_OFE: begin
                            if (c == ":") begin
                                s.rs = ST_OVAL;
                                s.st = ST_EWS;
                                brk  = 1'b1;
                            end else begin
                                fcode = ERR_NAME;
                            end
                        end
                        ST_OSEP: begin
                            if (c == "}") begin
                                push_ev(evs, n, EV_OBJ_END, 8'h00, 1'b0);
                                s.rs = ST_FIN;
                                s.st = ST_EWS;
                                brk  = 1'b1;
                            end else if (c == ",") begin
                                s.rs = ST_OFS;
                                s.st = ST_EWS;
                                brk  = 1'b1;
                            end else begin
                                fcode = ERR_SEPARATOR;
                            end
                        end
                        default: begin
                            fcode = ERR_UNEXPECTED;
                        end
                    endcase
                    if (fcode != ERR_NONE) begin
                        s.err = fcode;
                        push_ev(evs, n, EV_ERROR, 8'h00, 1'b0);
                        done   = 1'b1;
                        colinc = 1'b0;
                    end else if (ret) begin
                        done   = 1'b1;
                        colinc = 1'b0;
                    end else if (brk) begin
                        done = 1'b1;
                    end
                end
            end
            if (colinc) begin
                s.col = s.col + 32'd1;
            end
        end

        if (n == 2'd0) begin
            push_ev(evs, n, EV_NONE, 8'h00, 1'b0);
        end

        state_out     = s;
        depth_out     = d;
        stack_op      = sop;
        result.ev     = evs;
        result.count  = n;
        result.err    = s.err;
        result.line   = s.line;
        result.col    = s.col;
        result.nest   = 5'(d);
        result.fin    = (d == '0) && (s.st == ST_FIN);
    end

endmodule

/* rtl/jst_out_buf.sv */
// Result register that hands out the one to three events of an item in turn.
`timescale 1ns / 1ps
module jst_out_buf import jst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  tok_result_t res_in,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    tok_result_t res_reg;
    tok_result_t res_next;
    tok_event_t  cur;
    logic        at_last;

    assign at_last = (idx_reg == res_reg.count - 2'd1);
    assign free    = !valid_reg || (m_tready && at_last);

    always_comb begin
        unique case (idx_reg)
            2'd0:    cur = res_reg.ev[0];
            2'd1:    cur = res_reg.ev[1];
            default: cur = res_reg.ev[2];
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
            res_next   = res_in;
        end else if (valid_reg && m_tready) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = cur.kind;
    assign m_tlast  = at_last;
    assign m_tdata  = {5'd0, res_reg.fin, res_reg.nest, res_reg.col, res_reg.line,
                       res_reg.err, cur.dec, cur.data};

endmodule
